[hw/rtl/codec_config_to_annexb_macros.svh]
// Assertion macros used by the codec config converter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CODEC_CONFIG_TO_ANNEXB_MACROS_SVH
`define CODEC_CONFIG_TO_ANNEXB_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CCA_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cca_pkg.sv]
// Package for the codec config to Annex B converter: constants, codes, types.
// No dependencies; used by cca_step, cca_outbuf and codec_config_to_annexb.
package cca_pkg;

    localparam int SEARCH_WINDOW   = 4;
    localparam int HEVC_LEN_OFFSET = 21;
    localparam int AVC_LEN_POS     = 4;
    localparam int AVC_SPS_POS     = 5;

    localparam int WIN_NEED_RAW = SEARCH_WINDOW + 2;
    localparam int WIN_NEED     = (WIN_NEED_RAW < 4) ? 4 : ((WIN_NEED_RAW > 6) ? 6 : WIN_NEED_RAW);
    localparam int WIN_DEPTH    = WIN_NEED;
    localparam int RES_BYTES    = 8;
    localparam int TDATA_W      = 40;

    localparam logic [7:0]  BOX_TAG      = 8'h01;
    localparam logic [7:0]  SPS_CNT_MASK = 8'h1f;
    localparam logic [2:0]  LEN_SIZE_DEF = 3'd4;
    localparam logic [19:0] SIZE_MAX     = 20'hfffff;

    localparam logic [1:0] MODE_H264 = 2'd0;
    localparam logic [1:0] MODE_H265 = 2'd1;
    localparam logic [1:0] MODE_PASS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_HDR      = 4'd1,
        PH_LEN_HI   = 4'd2,
        PH_LEN_LO   = 4'd3,
        PH_PAYLOAD  = 4'd4,
        PH_COUNT    = 4'd5,
        PH_ARR_TYPE = 4'd6,
        PH_NUM_HI   = 4'd7,
        PH_NUM_LO   = 4'd8,
        PH_TAIL     = 4'd9,
        PH_WINDOW   = 4'd10,
        PH_PASS     = 4'd11,
        PH_DROP     = 4'd12,
        PH_THRU     = 4'd13
    } t_phase;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_DATA,
        EM_START_CODE,
        EM_WINDOW,
        EM_HELD
    } t_emit;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  hpos;
        logic [7:0]  lists;
        logic [15:0] nalus;
        logic [15:0] bytes_left;
        logic [7:0]  len_hi;
        logic [2:0]  size_len;
        logic [19:0] size_cnt;
        logic [7:0]  held;
    } t_state;

    localparam t_state STATE_INIT = '{phase: PH_START, hpos: 5'd0, lists: 8'd0,
                                      nalus: 16'd0, bytes_left: 16'd0, len_hi: 8'd0,
                                      size_len: LEN_SIZE_DEF, size_cnt: 20'd0,
                                      held: 8'h00};

    // results of one input word: up to WIN_DEPTH header bytes, then optional close
    typedef struct packed {
        logic [RES_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      fin;
        logic [1:0]                status;
        logic [2:0]                len_size;
        logic [19:0]               base;
    } t_step;

    typedef struct packed {
        logic [7:0]  data;
        logic        has;
        logic        eoh;
        logic [1:0]  status;
        logic [2:0]  len_size;
        logic [19:0] total;
    } t_result;

    function automatic logic [19:0] sat_add(input logic [19:0] a, input logic [2:0] k);
        logic [20:0] s;
        s = {1'b0, a} + 21'(k);
        return s[20] ? SIZE_MAX : s[19:0];
    endfunction

endpackage

[hw/rtl/cca_step.sv]
// Per-word parse step: next parser state and the result list for one input word.
// Depends on cca_pkg.
module cca_step (
    input  cca_pkg::t_state                         i_st,
    input  logic [cca_pkg::WIN_DEPTH-1:0][7:0]      i_win,
    input  logic [1:0]                              i_mode,
    input  logic [7:0]                              i_byte,
    input  logic                                    i_last,
    output cca_pkg::t_state                         o_st,
    output logic [cca_pkg::WIN_DEPTH-1:0][7:0]      o_win,
    output cca_pkg::t_step                          o_step
);

    typedef struct packed {
        cca_pkg::t_phase phase;
        logic [7:0]      lists;
    } t_le;

    cca_pkg::t_state                    n_st;
    logic [cca_pkg::WIN_DEPTH-1:0][7:0] n_win;
    cca_pkg::t_emit                     em;
    logic [2:0]                         cnt;
    logic                               fin;
    logic [1:0]                         fst;
    logic                               do_eval;
    logic                               found;
    logic [2:0]                         nn;
    logic [7:0]                         lb;
    logic [19:0]                        base;
    logic [15:0]                        dec;
    t_le                                le;
    logic [cca_pkg::RES_BYTES-1:0][7:0] bytes;

    // end of one SPS/PPS list or NAL array
    function automatic t_le list_end(input logic [1:0] mode, input logic [7:0] lists);
        t_le r;
        logic [7:0] l;
        if (mode == cca_pkg::MODE_H265) begin
            l = (lists != 8'd0) ? lists - 8'd1 : 8'd0;
            r.lists = l;
            r.phase = (l != 8'd0) ? cca_pkg::PH_ARR_TYPE : cca_pkg::PH_TAIL;
        end else if (lists == 8'd2) begin
            r.lists = 8'd1;
            r.phase = cca_pkg::PH_COUNT;
        end else begin
            r.lists = 8'd0;
            r.phase = cca_pkg::PH_TAIL;
        end
        return r;
    endfunction

    always_comb begin : next_state
        n_st    = i_st;
        n_win   = i_win;
        em      = cca_pkg::EM_NONE;
        cnt     = 3'd0;
        fin     = 1'b0;
        fst     = cca_pkg::ST_OK;
        do_eval = 1'b0;
        found   = 1'b0;
        nn      = 3'd0;
        lb      = 8'h00;
        dec     = 16'd0;
        le      = '0;
        base    = (i_st.phase == cca_pkg::PH_START) ? 20'd0 : i_st.size_cnt;
        case (i_st.phase)
            cca_pkg::PH_START: begin
                n_st.hpos       = 5'd0;
                n_st.lists      = 8'd0;
                n_st.nalus      = 16'd0;
                n_st.bytes_left = 16'd0;
                n_st.len_hi     = 8'd0;
                n_st.size_len   = cca_pkg::LEN_SIZE_DEF;
                n_st.held       = 8'h00;
                if (i_mode >= cca_pkg::MODE_PASS) begin
                    em         = cca_pkg::EM_DATA;
                    cnt        = 3'd1;
                    n_st.phase = cca_pkg::PH_THRU;
                end else if (i_byte == cca_pkg::BOX_TAG && !i_last) begin
                    n_st.hpos  = 5'd1;
                    n_st.phase = cca_pkg::PH_HDR;
                end else begin
                    n_win[0]   = i_byte;
                    n_st.hpos  = 5'd1;
                    n_st.phase = cca_pkg::PH_WINDOW;
                    do_eval    = i_last;
                end
            end
            cca_pkg::PH_HDR: begin
                if (i_st.hpos != 5'd31) begin
                    n_st.hpos = i_st.hpos + 5'd1;
                end
                if (i_mode == cca_pkg::MODE_H265) begin
                    if (i_st.hpos == 5'(cca_pkg::HEVC_LEN_OFFSET)) begin
                        n_st.size_len = {1'b0, i_byte[1:0]} + 3'd1;
                    end else if (i_st.hpos > 5'(cca_pkg::HEVC_LEN_OFFSET)) begin
                        n_st.lists = i_byte;
                        n_st.phase = (i_byte != 8'd0) ? cca_pkg::PH_ARR_TYPE : cca_pkg::PH_TAIL;
                    end
                end else begin
                    if (i_st.hpos == 5'(cca_pkg::AVC_LEN_POS)) begin
                        n_st.size_len = {1'b0, i_byte[1:0]} + 3'd1;
                    end else if (i_st.hpos >= 5'(cca_pkg::AVC_SPS_POS)) begin
                        n_st.nalus = {8'd0, i_byte & cca_pkg::SPS_CNT_MASK};
                        if ((i_byte & cca_pkg::SPS_CNT_MASK) != 8'd0) begin
                            n_st.lists = 8'd2;
                            n_st.phase = cca_pkg::PH_LEN_HI;
                        end else begin
                            le         = list_end(i_mode, 8'd2);
                            n_st.lists = le.lists;
                            n_st.phase = le.phase;
                        end
                    end
                end
            end
            cca_pkg::PH_LEN_HI: begin
                n_st.len_hi = i_byte;
                n_st.phase  = cca_pkg::PH_LEN_LO;
            end
            cca_pkg::PH_LEN_LO: begin
                n_st.bytes_left = {i_st.len_hi, i_byte};
                em              = cca_pkg::EM_START_CODE;
                cnt             = 3'd4;
                if ({i_st.len_hi, i_byte} != 16'd0) begin
                    n_st.phase = cca_pkg::PH_PAYLOAD;
                end else begin
                    dec        = (i_st.nalus != 16'd0) ? i_st.nalus - 16'd1 : 16'd0;
                    n_st.nalus = dec;
                    if (dec != 16'd0) begin
                        n_st.phase = cca_pkg::PH_LEN_HI;
                    end else begin
                        le         = list_end(i_mode, i_st.lists);
                        n_st.lists = le.lists;
                        n_st.phase = le.phase;
                    end
                end
            end
            cca_pkg::PH_PAYLOAD: begin
                em              = cca_pkg::EM_DATA;
                cnt             = 3'd1;
                n_st.bytes_left = (i_st.bytes_left != 16'd0) ? i_st.bytes_left - 16'd1 : 16'd0;
                if (n_st.bytes_left == 16'd0) begin
                    dec        = (i_st.nalus != 16'd0) ? i_st.nalus - 16'd1 : 16'd0;
                    n_st.nalus = dec;
                    if (dec != 16'd0) begin
                        n_st.phase = cca_pkg::PH_LEN_HI;
                    end else begin
                        le         = list_end(i_mode, i_st.lists);
                        n_st.lists = le.lists;
                        n_st.phase = le.phase;
                    end
                end
            end
            cca_pkg::PH_COUNT: begin
                n_st.nalus = {8'd0, i_byte};
                if (i_byte != 8'd0) begin
                    n_st.phase = cca_pkg::PH_LEN_HI;
                end else begin
                    le         = list_end(i_mode, i_st.lists);
                    n_st.lists = le.lists;
                    n_st.phase = le.phase;
                end
            end
            cca_pkg::PH_ARR_TYPE: begin
                n_st.phase = cca_pkg::PH_NUM_HI;
            end
            cca_pkg::PH_NUM_HI: begin
                n_st.len_hi = i_byte;
                n_st.phase  = cca_pkg::PH_NUM_LO;
            end
            cca_pkg::PH_NUM_LO: begin
                n_st.nalus = {i_st.len_hi, i_byte};
                if ({i_st.len_hi, i_byte} != 16'd0) begin
                    n_st.phase = cca_pkg::PH_LEN_HI;
                end else begin
                    le         = list_end(i_mode, i_st.lists);
                    n_st.lists = le.lists;
                    n_st.phase = le.phase;
                end
            end
            cca_pkg::PH_WINDOW: begin
                for (int i = 0; i < cca_pkg::WIN_DEPTH; i++) begin
                    if (i_st.hpos == 5'(i)) begin
                        n_win[i] = i_byte;
                    end
                end
                n_st.hpos = i_st.hpos + 5'd1;
                do_eval   = i_last || (n_st.hpos >= 5'(cca_pkg::WIN_NEED));
            end
            cca_pkg::PH_PASS: begin
                em = cca_pkg::EM_HELD;
                if (i_last) begin
                    n_st.held = 8'h00;
                    cnt       = (i_mode == cca_pkg::MODE_H264 && i_byte == 8'h00) ? 3'd1 : 3'd2;
                    fin       = 1'b1;
                end else begin
                    n_st.held = i_byte;
                    cnt       = 3'd1;
                end
            end
            cca_pkg::PH_THRU: begin
                em  = cca_pkg::EM_DATA;
                cnt = 3'd1;
            end
            cca_pkg::PH_TAIL, cca_pkg::PH_DROP: begin
            end
            default: begin
                n_st.phase = cca_pkg::PH_DROP;
            end
        endcase

        // start-code search over the gathered window
        if (do_eval) begin
            nn = n_st.hpos[2:0];
            if (nn <= 3'd3) begin
                fin = 1'b1;
            end else begin
                for (int k = 0; k < cca_pkg::SEARCH_WINDOW; k++) begin
                    if ((k + 2 < int'(nn)) && n_win[k] == 8'h00 && n_win[k+1] == 8'h00 &&
                        n_win[k+2] == 8'h01) begin
                        found = 1'b1;
                    end
                end
                for (int i = 0; i < cca_pkg::WIN_DEPTH; i++) begin
                    if (3'(i) == nn - 3'd1) begin
                        lb = n_win[i];
                    end
                end
                if (!found) begin
                    if (i_last) begin
                        fin = 1'b1;
                        fst = cca_pkg::ST_INVALID;
                    end else begin
                        n_st.phase = cca_pkg::PH_DROP;
                    end
                end else begin
                    em = cca_pkg::EM_WINDOW;
                    if (i_last) begin
                        cnt = (i_mode == cca_pkg::MODE_H264 && lb == 8'h00) ? nn - 3'd1 : nn;
                        fin = 1'b1;
                    end else begin
                        cnt        = nn - 3'd1;
                        n_st.held  = lb;
                        n_st.phase = cca_pkg::PH_PASS;
                    end
                end
            end
        end

        if (i_last && !fin) begin
            fin = 1'b1;
            case (n_st.phase)
                cca_pkg::PH_TAIL, cca_pkg::PH_THRU: fst = cca_pkg::ST_OK;
                cca_pkg::PH_DROP:                   fst = cca_pkg::ST_INVALID;
                default:                            fst = cca_pkg::ST_TRUNC;
            endcase
        end
        if (fin) begin
            n_st.phase = cca_pkg::PH_START;
        end
        n_st.size_cnt = cca_pkg::sat_add(base, cnt);
    end

    always_comb begin : result_list
        bytes = '0;
        case (em)
            cca_pkg::EM_DATA: begin
                bytes[0] = i_byte;
            end
            cca_pkg::EM_START_CODE: begin
                bytes[3] = 8'h01;
            end
            cca_pkg::EM_WINDOW: begin
                for (int i = 0; i < cca_pkg::WIN_DEPTH; i++) begin
                    bytes[i] = n_win[i];
                end
            end
            cca_pkg::EM_HELD: begin
                bytes[0] = i_st.held;
                bytes[1] = i_byte;
            end
            default: begin
                bytes = '0;
            end
        endcase
        o_step.bytes    = bytes;
        o_step.nbytes   = cnt;
        o_step.fin      = fin;
        o_step.status   = fst;
        o_step.len_size = n_st.size_len;
        o_step.base     = base;
    end

    assign o_st  = n_st;
    assign o_win = n_win;

endmodule

[hw/rtl/cca_outbuf.sv]
// Result register: holds the result list of one input word and drains one per cycle while i_ready is high.
// Depends on cca_pkg and codec_config_to_annexb_macros.svh.
`include "codec_config_to_annexb_macros.svh"

module cca_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cca_pkg::t_step   i_step,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output cca_pkg::t_result o_res
);

    cca_pkg::t_step r_step;
    logic [2:0]     r_nent;
    logic [2:0]     r_idx;
    logic [19:0]    r_cnt;
    logic [2:0]     n_nent;
    logic [2:0]     n_idx;
    logic [19:0]    n_cnt;
    logic           take;
    logic           has;

    assign o_valid    = (r_idx != r_nent);
    assign take       = o_valid && i_ready;
    assign o_can_load = !o_valid || (take && (4'(r_idx) + 4'd1 == 4'(r_nent)));
    assign has        = (r_idx < r_step.nbytes);

    always_comb begin
        o_res.data     = has ? r_step.bytes[r_idx] : 8'h00;
        o_res.has      = has;
        o_res.eoh      = !has;
        o_res.status   = has ? cca_pkg::ST_OK : r_step.status;
        o_res.len_size = r_step.len_size;
        o_res.total    = has ? cca_pkg::sat_add(r_cnt, 3'd1) : r_cnt;
    end

    always_comb begin
        n_nent = r_nent;
        n_idx  = r_idx;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_nent = i_step.nbytes + 3'(i_step.fin);
            n_idx  = 3'd0;
            n_cnt  = i_step.base;
        end else if (take) begin
            n_idx = r_idx + 3'd1;
            n_cnt = o_res.total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nent <= 3'd0;
            r_idx  <= 3'd0;
        end else begin
            r_nent <= n_nent;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (i_load) begin
            r_step <= i_step;
        end
    end

    `CCA_ASSERT(a_idx_bound, i_clk, i_rst_n, r_idx <= r_nent, "read index past list end")
    `CCA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(r_idx) && $stable(r_nent), "stalled list moved")
    `CCA_ASSERT(a_close_last, i_clk, i_rst_n, !(o_valid && o_res.eoh) || (4'(r_idx) + 4'd1 == 4'(r_nent)), "close word not last in list")
    `CCA_ASSERT_NEXT(a_total_carry, i_clk, i_rst_n, take && !i_load, r_cnt == $past(o_res.total), "running size lost")

endmodule

[hw/rtl/codec_config_to_annexb.sv]
// Codec configuration (avcC / hvcC / raw) to Annex B sequence header converter.
// Takes one configuration byte per input word and streams the header bytes out.
// Input: s_axis words, tdata[7:0] = config byte, tlast = final byte of the header.
// Output: m_axis words, tuser = byte present, tlast = closing status word.
// Config: i_cfg_valid/i_cfg_data write codec_mode (0 H.264, 1 H.265, else pass);
//   ready is always high, write it only while no header is in flight.
// Each accepted word is parsed combinationally into up to seven output words
//   (data, start codes, released search window, held byte, closing status).
// A word's results are valid once it has passed the input register and
//   been loaded into the result register, which waits for the prior list.
// Throughput: one input word per cycle while each word yields at most one
//   result and m_axis tready is high; a word yielding several results holds
//   the output until all are taken, and the input stalls (tready low) until
//   its list drains; the result register drains one word per ready cycle.
// A downstream stall holds the current output word and, after the input
//   register fills, deasserts s_axis tready.
// Reset (synchronous, active low) empties both registers, restores the
//   parser to header start with length size 4 and sets codec_mode to 0.
// Depends on cca_pkg, cca_step and cca_outbuf.
module codec_config_to_annexb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] in_byte
    input  logic                        i_s_axis_tlast,  // in_last
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [7:0] out_byte, [9:8] status, [12:10] length_size, [32:13] total_size
    output logic [cca_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tuser,  // has_byte
    output logic                        o_m_axis_tlast,  // end_of_header
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data       // codec_mode
);

    logic                               r_in_v;
    logic [7:0]                         r_in_byte;
    logic                               r_in_last;
    logic [1:0]                         r_mode;
    cca_pkg::t_state                    r_st;
    logic [cca_pkg::WIN_DEPTH-1:0][7:0] r_win;
    cca_pkg::t_state                    n_st;
    logic [cca_pkg::WIN_DEPTH-1:0][7:0] n_win;
    cca_pkg::t_step                     step;
    cca_pkg::t_result                   res;
    logic                               can_load;
    logic                               load;
    logic                               in_take;

    assign load            = r_in_v && can_load;
    assign o_s_axis_tready = !r_in_v || load;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    cca_step u_step (
        .i_st   (r_st),
        .i_win  (r_win),
        .i_mode (r_mode),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_st   (n_st),
        .o_win  (n_win),
        .o_step (step)
    );

    cca_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_step     (step),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_mode <= cca_pkg::MODE_H264;
            r_st   <= cca_pkg::STATE_INIT;
        end else begin
            if (in_take) begin
                r_in_v <= 1'b1;
            end else if (load) begin
                r_in_v <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (load) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (load) begin
            r_win <= n_win;
        end
    end

    assign o_m_axis_tdata = {7'd0, res.total, res.len_size, res.status, res.data};
    assign o_m_axis_tuser = res.has;
    assign o_m_axis_tlast = res.eoh;

endmodule
